// ----- rtl/rpc_pkg.sv -----
package rpc_pkg;

    // scan mode codes
    localparam logic [1:0] MODE_SURV = 2'd0;
    localparam logic [1:0] MODE_RHI  = 2'd1;
    localparam logic [1:0] MODE_AIR  = 2'd2;

    localparam int OUT_W = 24;

    // fixed point: Q30 radians and Q30 trig values
    localparam logic [30:0] Q_ONE    = 31'h4000_0000;
    localparam logic [30:0] PIO2_Q30 = 31'd1686629713;

    // ranges below MIN_RANGE give a zero position
    localparam int MIN_RANGE = 4;

    // horner divisors, innermost (highest order) term first
    localparam int SIN_N = 7;
    localparam int COS_N = 8;
    localparam int SIN_DIV [0:SIN_N-1] = '{210, 156, 110, 72, 42, 20, 6};
    localparam int COS_DIV [0:COS_N-1] = '{240, 182, 132, 90, 56, 30, 12, 2};

    // cycles from angle register to sin/cos register
    localparam int SC_LAT = 27;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [33:0] fac_t;

    // q60 to q30, half away from zero
    function automatic fac_t rnd30(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v + 64'sd536870912 - {63'd0, v[63]};
        return fac_t'(s >>> 30);
    endfunction

endpackage

// ----- rtl/rpc_horner_cell.sv -----
module rpc_horner_cell #(
    parameter int DIV = 2
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] t2_in,
    input  logic [30:0] h_in,
    output logic [31:0] t2_out,
    output logic [30:0] h_out
);
    import rpc_pkg::*;

    localparam int          L       = $clog2(DIV);
    localparam int          SH      = 32 + L;
    localparam logic [63:0] MAGIC   = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [62:0] ROUND_C = 63'(DIV) << 29;

    logic [62:0] p_reg;
    logic [31:0] x_reg;
    logic [31:0] q_reg;
    logic [31:0] t2_reg [0:2];
    logic [64:0] qprod;

    // exact floor division by the constant through a reciprocal
    assign qprod = 65'(x_reg) * 65'(MAGIC[32:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= 63'(t2_in) * 63'(h_in);
            x_reg     <= 32'((p_reg + ROUND_C) >> 30);
            q_reg     <= 32'(qprod >> SH);
            t2_reg[0] <= t2_in;
            t2_reg[1] <= t2_reg[0];
            t2_reg[2] <= t2_reg[1];
        end
    end

    assign t2_out = t2_reg[2];
    assign h_out  = (q_reg > 32'(Q_ONE)) ? 31'd0 : Q_ONE - q_reg[30:0];

endmodule

// ----- rtl/rpc_sincos.sv -----
module rpc_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output rpc_pkg::q30_t         sin_q30,
    output rpc_pkg::q30_t         cos_q30
);
    import rpc_pkg::*;

    localparam int RW = ANGLE_BITS - 2;
    localparam int PW = RW + 31;
    localparam int T_DLY = 22;
    localparam int Q_DLY = 25;

    logic [PW-1:0] tprod;
    logic [61:0]   sq;
    logic [61:0]   sprod;
    logic [30:0]   t_reg;
    logic [1:0]    quad_reg;
    logic [31:0]   t2_reg;
    logic [30:0]   t_dly_reg [0:T_DLY-1];
    logic [1:0]    quad_dly_reg [0:Q_DLY-1];
    logic [30:0]   s_reg [0:2];
    q30_t          sin_reg;
    q30_t          cos_reg;
    q30_t          sin_next;
    q30_t          cos_next;
    q30_t          s_v;
    q30_t          c_v;

    logic [31:0] cos_t2 [0:COS_N];
    logic [30:0] cos_h  [0:COS_N];
    logic [31:0] sin_t2 [0:SIN_N];
    logic [30:0] sin_h  [0:SIN_N];

    assign tprod = PW'(angle[RW-1:0]) * PW'(PIO2_Q30) + (PW'(1) << (RW - 1));
    assign sq    = 62'(t_reg) * 62'(t_reg) + (62'(1) << 29);
    assign sprod = 62'(t_dly_reg[T_DLY-1]) * 62'(sin_h[SIN_N]) + (62'(1) << 29);

    assign cos_t2[0] = t2_reg;
    assign cos_h[0]  = Q_ONE;
    assign sin_t2[0] = t2_reg;
    assign sin_h[0]  = Q_ONE;

    for (genvar i = 0; i < COS_N; i++) begin : g_cos
        rpc_horner_cell #(.DIV(COS_DIV[i])) u_cell (
            .aclk   (aclk),
            .en     (en),
            .t2_in  (cos_t2[i]),
            .h_in   (cos_h[i]),
            .t2_out (cos_t2[i+1]),
            .h_out  (cos_h[i+1])
        );
    end

    for (genvar i = 0; i < SIN_N; i++) begin : g_sin
        rpc_horner_cell #(.DIV(SIN_DIV[i])) u_cell (
            .aclk   (aclk),
            .en     (en),
            .t2_in  (sin_t2[i]),
            .h_in   (sin_h[i]),
            .t2_out (sin_t2[i+1]),
            .h_out  (sin_h[i+1])
        );
    end

    // quadrant fold
    always_comb begin
        s_v = q30_t'({1'b0, s_reg[2]});
        c_v = q30_t'({1'b0, cos_h[COS_N]});
        case (quad_dly_reg[Q_DLY-1])
            2'd0: begin sin_next = s_v;  cos_next = c_v;  end
            2'd1: begin sin_next = c_v;  cos_next = -s_v; end
            2'd2: begin sin_next = -s_v; cos_next = -c_v; end
            default: begin sin_next = -c_v; cos_next = s_v; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg    <= tprod[RW+30:RW];
            quad_reg <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
            t2_reg   <= sq[61:30];
            t_dly_reg[0]    <= t_reg;
            quad_dly_reg[0] <= quad_reg;
            for (int i = 1; i < T_DLY; i++) begin
                t_dly_reg[i] <= t_dly_reg[i-1];
            end
            for (int i = 1; i < Q_DLY; i++) begin
                quad_dly_reg[i] <= quad_dly_reg[i-1];
            end
            s_reg[0] <= sprod[60:30];
            s_reg[1] <= s_reg[0];
            s_reg[2] <= s_reg[1];
            sin_reg  <= sin_next;
            cos_reg  <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

// ----- rtl/radar_polar_to_cartesian_unit.sv -----
// throughput: one gate per cycle, sustained while the result side takes transfers
// the pipeline depth is set by the cosine horner chain: eight cells of three stages each
// a result held back by m_tready stalls the whole pipeline in place
// reset (aresetn low, synchronous) empties the pipeline and sets scan mode to surveillance
module radar_polar_to_cartesian_unit #(
    parameter int RANGE_BITS = 23,
    parameter int ANGLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slant_range, rotation, tilt_angle, heading_angle, zero pad
    input  logic [((RANGE_BITS+3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // x_pos, y_pos, z_pos
    output logic [71:0] m_tdata
);
    import rpc_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int RB = RANGE_BITS;
    localparam int L_M1 = SC_LAT + 1;
    localparam int L_OUT = L_M1 + 6;
    localparam int RNG_N = L_M1 + 5;
    // wide enough for the range product and for the output slice
    localparam int PRW = (RB + 33 > OUT_W + 30) ? RB + 33 : OUT_W + 30;
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    logic          en;
    logic [1:0]    scan_mode_reg;
    logic          vld_reg [0:L_OUT];
    logic [RB-1:0] rng_reg [0:RNG_N-1];
    logic [AB-1:0] rot_reg;
    logic [AB-1:0] tilt_reg;
    logic [AB-1:0] head_reg;
    logic [AB-1:0] cart;

    q30_t sr, cr, st, ct, sh, ch;

    logic signed [63:0] p_ctcr_reg, p_ctsr_reg, p_crst_reg;
    q30_t st1_reg, sr1_reg, sh1_reg, ch1_reg;
    fac_t a2_reg, ctsr2_reg, crst2_reg;
    q30_t st2_reg, sr2_reg, sh2_reg, ch2_reg;
    logic signed [63:0] m_ach_reg, m_stsh_reg, m_ash_reg, m_stch_reg;
    fac_t a3_reg, ctsr3_reg, crst3_reg;
    q30_t st3_reg, sr3_reg;
    fac_t ax4_reg, ay4_reg, a4_reg, ctsr4_reg, crst4_reg;
    q30_t st4_reg, sr4_reg;
    fac_t fx_reg, fy_reg, fz_reg;
    fac_t fx_next, fy_next, fz_next;
    logic [PRW-1:0] px_reg, py_reg, pz_reg;
    logic           nx_reg, ny_reg, nz_reg, short_reg;
    logic [PRW-1:0] sx, sy, sz;
    logic [OUT_W-1:0] x_reg, y_reg, z_reg;

    assign en       = !vld_reg[L_OUT] || m_tready;
    assign s_tready = en;
    assign cart     = QUARTER - s_tdata[RB +: AB];

    rpc_sincos #(.ANGLE_BITS(AB)) u_sc_rot (
        .aclk(aclk), .en(en), .angle(rot_reg), .sin_q30(sr), .cos_q30(cr)
    );
    rpc_sincos #(.ANGLE_BITS(AB)) u_sc_tilt (
        .aclk(aclk), .en(en), .angle(tilt_reg), .sin_q30(st), .cos_q30(ct)
    );
    rpc_sincos #(.ANGLE_BITS(AB)) u_sc_head (
        .aclk(aclk), .en(en), .angle(head_reg), .sin_q30(sh), .cos_q30(ch)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode_reg <= MODE_SURV;
        end else if (cfg_wr_en) begin
            scan_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= L_OUT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= L_OUT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // factor select by scan mode; unused code acts as surveillance
    always_comb begin
        unique case (scan_mode_reg)
            MODE_AIR: begin
                fx_next = ax4_reg;
                fy_next = ay4_reg;
                fz_next = ctsr4_reg;
            end
            MODE_RHI: begin
                fx_next = a4_reg;
                fy_next = crst4_reg;
                fz_next = fac_t'(sr4_reg);
            end
            default: begin
                fx_next = a4_reg;
                fy_next = ctsr4_reg;
                fz_next = fac_t'(st4_reg);
            end
        endcase
    end

    assign sx = px_reg + (PRW'(1) << 29);
    assign sy = py_reg + (PRW'(1) << 29);
    assign sz = pz_reg + (PRW'(1) << 29);

    always_ff @(posedge aclk) begin
        if (en) begin
            rng_reg[0] <= s_tdata[RB-1:0];
            for (int i = 1; i < RNG_N; i++) begin
                rng_reg[i] <= rng_reg[i-1];
            end
            rot_reg  <= cart;
            tilt_reg <= s_tdata[RB+AB +: AB];
            head_reg <= s_tdata[RB+2*AB +: AB];

            p_ctcr_reg <= 64'(ct) * 64'(cr);
            p_ctsr_reg <= 64'(ct) * 64'(sr);
            p_crst_reg <= 64'(cr) * 64'(st);
            st1_reg <= st;
            sr1_reg <= sr;
            sh1_reg <= sh;
            ch1_reg <= ch;

            a2_reg    <= rnd30(p_ctcr_reg);
            ctsr2_reg <= rnd30(p_ctsr_reg);
            crst2_reg <= rnd30(p_crst_reg);
            st2_reg <= st1_reg;
            sr2_reg <= sr1_reg;
            sh2_reg <= sh1_reg;
            ch2_reg <= ch1_reg;

            m_ach_reg  <= 64'(a2_reg) * 64'(ch2_reg);
            m_stsh_reg <= 64'(st2_reg) * 64'(sh2_reg);
            m_ash_reg  <= 64'(a2_reg) * 64'(sh2_reg);
            m_stch_reg <= 64'(st2_reg) * 64'(ch2_reg);
            a3_reg    <= a2_reg;
            ctsr3_reg <= ctsr2_reg;
            crst3_reg <= crst2_reg;
            st3_reg   <= st2_reg;
            sr3_reg   <= sr2_reg;

            // airborne rotation by heading
            ax4_reg   <= rnd30(m_ach_reg - m_stsh_reg);
            ay4_reg   <= rnd30(m_ash_reg + m_stch_reg);
            a4_reg    <= a3_reg;
            ctsr4_reg <= ctsr3_reg;
            crst4_reg <= crst3_reg;
            st4_reg   <= st3_reg;
            sr4_reg   <= sr3_reg;

            fx_reg <= fx_next;
            fy_reg <= fy_next;
            fz_reg <= fz_next;

            px_reg <= PRW'(rng_reg[RNG_N-1]) * PRW'(fx_reg[33] ? -fx_reg : fx_reg);
            py_reg <= PRW'(rng_reg[RNG_N-1]) * PRW'(fy_reg[33] ? -fy_reg : fy_reg);
            pz_reg <= PRW'(rng_reg[RNG_N-1]) * PRW'(fz_reg[33] ? -fz_reg : fz_reg);
            nx_reg <= fx_reg[33];
            ny_reg <= fy_reg[33];
            nz_reg <= fz_reg[33];
            short_reg <= (rng_reg[RNG_N-1] < RB'(MIN_RANGE));

            x_reg <= short_reg ? '0 : (nx_reg ? -sx[53:30] : sx[53:30]);
            y_reg <= short_reg ? '0 : (ny_reg ? -sy[53:30] : sy[53:30]);
            z_reg <= short_reg ? '0 : (nz_reg ? -sz[53:30] : sz[53:30]);
        end
    end

    assign m_tvalid = vld_reg[L_OUT];
    assign m_tdata  = {z_reg, y_reg, x_reg};

    a_block_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result blocked");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transfer lost at entry");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && $past(aresetn)) |=> ($stable(vld_reg[L_OUT]) && $stable(x_reg)))
        else $error("pipeline moved while stalled");

endmodule
